/* rtl/fhcc_pkg.sv */
package fhcc_pkg;

  localparam int COUNT_BITS = 24;
  localparam int PAYLOAD_W  = 24;
  localparam int CNT_CMP_W  = ((COUNT_BITS > PAYLOAD_W) ? COUNT_BITS : PAYLOAD_W) + 1;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef enum logic [2:0] {
    STATUS_OK            = 3'd0,
    STATUS_INVALID       = 3'd1,
    STATUS_NOT_SUPPORTED = 3'd2,
    STATUS_TOO_BIG       = 3'd3,
    STATUS_BAD_CRC       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FUNC_HEADER = 2'd0,
    FUNC_BYTE   = 2'd1,
    FUNC_END    = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC         = 3'd0,
    REG_VERSION       = 3'd1,
    REG_PANEL_WIDTH   = 3'd2,
    REG_PANEL_HEIGHT  = 3'd3,
    REG_PIXEL_FORMAT  = 3'd4,
    REG_PAYLOAD_BYTES = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]          expected_magic;
    logic [15:0]          expected_version;
    logic [15:0]          panel_width;
    logic [15:0]          panel_height;
    logic [7:0]           pixel_format_code;
    logic [PAYLOAD_W-1:0] payload_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] hdr_magic;
    logic [15:0] hdr_version;
    logic [15:0] hdr_width;
    logic [15:0] hdr_height;
    logic [7:0]  hdr_format;
    logic [31:0] hdr_payload_len;
    logic [31:0] hdr_crc;
    logic [7:0]  data_byte;
  } item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = ~crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

/* rtl/fhcc_cfg_regs.sv */
module fhcc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fhcc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output fhcc_pkg::cfg_t                   cfg
);
  import fhcc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MAGIC:         cfg_nxt.expected_magic    = pwdata;
        REG_VERSION:       cfg_nxt.expected_version  = pwdata[15:0];
        REG_PANEL_WIDTH:   cfg_nxt.panel_width       = pwdata[15:0];
        REG_PANEL_HEIGHT:  cfg_nxt.panel_height      = pwdata[15:0];
        REG_PIXEL_FORMAT:  cfg_nxt.pixel_format_code = pwdata[7:0];
        REG_PAYLOAD_BYTES: cfg_nxt.payload_bytes     = pwdata[PAYLOAD_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAGIC:         prdata = cfg_r.expected_magic;
      REG_VERSION:       prdata = {16'd0, cfg_r.expected_version};
      REG_PANEL_WIDTH:   prdata = {16'd0, cfg_r.panel_width};
      REG_PANEL_HEIGHT:  prdata = {16'd0, cfg_r.panel_height};
      REG_PIXEL_FORMAT:  prdata = {24'd0, cfg_r.pixel_format_code};
      REG_PAYLOAD_BYTES: prdata = {{(32-PAYLOAD_W){1'b0}}, cfg_r.payload_bytes};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/fhcc_core.sv */
module fhcc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  fhcc_pkg::item_t  item,
  input  fhcc_pkg::cfg_t   cfg,
  output fhcc_pkg::status_t res_status,
  output logic [31:0]      res_crc
);
  import fhcc_pkg::*;

  logic                  header_valid_r;
  logic                  header_valid_nxt;
  logic [31:0]           expected_crc_r;
  logic [31:0]           expected_crc_nxt;
  logic [31:0]           crc_acc_r;
  logic [31:0]           crc_acc_nxt;
  logic [COUNT_BITS-1:0] bytes_seen_r;
  logic [COUNT_BITS-1:0] bytes_seen_nxt;
  logic [CNT_CMP_W-1:0]  seen_ext;
  logic [CNT_CMP_W-1:0]  seen_inc;
  logic [CNT_CMP_W-1:0]  limit_ext;
  status_t               hdr_status;

  assign seen_ext  = {{(CNT_CMP_W-COUNT_BITS){1'b0}}, bytes_seen_r};
  assign seen_inc  = seen_ext + {{(CNT_CMP_W-1){1'b0}}, 1'b1};
  assign limit_ext = {{(CNT_CMP_W-PAYLOAD_W){1'b0}}, cfg.payload_bytes};

  always_comb begin
    if (item.hdr_magic != cfg.expected_magic) begin
      hdr_status = STATUS_INVALID;
    end else if (item.hdr_version != cfg.expected_version) begin
      hdr_status = STATUS_NOT_SUPPORTED;
    end else if (item.hdr_width != cfg.panel_width ||
                 item.hdr_height != cfg.panel_height) begin
      hdr_status = STATUS_INVALID;
    end else if (item.hdr_format != cfg.pixel_format_code) begin
      hdr_status = STATUS_NOT_SUPPORTED;
    end else if (item.hdr_payload_len !=
                 {{(32-PAYLOAD_W){1'b0}}, cfg.payload_bytes}) begin
      hdr_status = STATUS_INVALID;
    end else begin
      hdr_status = STATUS_OK;
    end
  end

  always_comb begin
    header_valid_nxt = header_valid_r;
    expected_crc_nxt = expected_crc_r;
    crc_acc_nxt      = crc_acc_r;
    bytes_seen_nxt   = bytes_seen_r;
    res_status       = STATUS_INVALID;
    case (func_t'(item.func))
      FUNC_HEADER: begin
        res_status = hdr_status;
        if (hdr_status == STATUS_OK) begin
          header_valid_nxt = 1'b1;
          expected_crc_nxt = item.hdr_crc;
          crc_acc_nxt      = 32'd0;
          bytes_seen_nxt   = '0;
        end else begin
          header_valid_nxt = 1'b0;
        end
      end
      FUNC_BYTE: begin
        if (!header_valid_r) begin
          res_status = STATUS_INVALID;
        end else if (seen_inc > limit_ext) begin
          res_status = STATUS_TOO_BIG;
        end else begin
          res_status     = STATUS_OK;
          crc_acc_nxt    = crc_byte(crc_acc_r, item.data_byte);
          bytes_seen_nxt = seen_inc[COUNT_BITS-1:0];
        end
      end
      FUNC_END: begin
        if (!header_valid_r || seen_ext != limit_ext) begin
          res_status = STATUS_INVALID;
        end else if (crc_acc_r != expected_crc_r) begin
          res_status = STATUS_BAD_CRC;
        end else begin
          res_status = STATUS_OK;
        end
      end
      default: res_status = STATUS_INVALID;
    endcase
  end

  assign res_crc = crc_acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_valid_r <= 1'b0;
      expected_crc_r <= 32'd0;
      crc_acc_r      <= 32'd0;
      bytes_seen_r   <= '0;
    end else if (step) begin
      header_valid_r <= header_valid_nxt;
      expected_crc_r <= expected_crc_nxt;
      crc_acc_r      <= crc_acc_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
    end
  end

endmodule

/* rtl/frame_header_crc_checker_top.sv */
// Frame checker: every request (a header, one payload byte or an end-of-frame mark) yields
// exactly one result holding a status code and the CRC-32 of the payload accepted so far.
// A request is captured in an input register and handled, once the output register can take
// its result, by the header compare and a one-byte CRC-32 update against the frame state; the
// result then sits in an output register. One request is taken every clock cycle when the
// result side keeps up. The user must write configuration registers over the APB port only
// while no request is in flight; the block itself does not enforce this.
module frame_header_crc_checker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_func,
  input  logic [31:0]                      in_hdr_magic,
  input  logic [15:0]                      in_hdr_version,
  input  logic [15:0]                      in_hdr_width,
  input  logic [15:0]                      in_hdr_height,
  input  logic [7:0]                       in_hdr_format,
  input  logic [31:0]                      in_hdr_payload_len,
  input  logic [31:0]                      in_hdr_crc,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [31:0]                      out_running_crc,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fhcc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import fhcc_pkg::*;

  cfg_t        cfg;
  item_t       item_r;
  logic        item_valid_r;
  logic        advance;
  status_t     res_status;
  logic [31:0] res_crc;
  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_crc_r;

  fhcc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fhcc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (item_r),
    .cfg        (cfg),
    .res_status (res_status),
    .res_crc    (res_crc)
  );

  assign advance  = item_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~item_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func            <= in_func;
      item_r.hdr_magic       <= in_hdr_magic;
      item_r.hdr_version     <= in_hdr_version;
      item_r.hdr_width       <= in_hdr_width;
      item_r.hdr_height      <= in_hdr_height;
      item_r.hdr_format      <= in_hdr_format;
      item_r.hdr_payload_len <= in_hdr_payload_len;
      item_r.hdr_crc         <= in_hdr_crc;
      item_r.data_byte       <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= res_status;
      out_crc_r    <= res_crc;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_running_crc = out_crc_r;

endmodule

/* test/frame_header_crc_checker_top_tb.sv */
`timescale 1ns / 100ps

module frame_header_crc_checker_top_tb;
  import fhcc_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [31:0] IEEE_POLY   = 32'hEDB88320;
  localparam logic [1:0]  FUNC_SPARE  = 2'd3;
  localparam int          MAX_BODY    = 20;

  typedef struct packed {
    status_t     status;
    logic [31:0] crc;
  } frame_result_t;

  typedef enum {BODY_EXACT, BODY_SHORT, BODY_LONG} body_shape_t;

  class frame_status_board;
    logic [31:0]           cfg_magic;
    logic [15:0]           cfg_version;
    logic [15:0]           cfg_width;
    logic [15:0]           cfg_height;
    logic [7:0]            cfg_format;
    logic [PAYLOAD_W-1:0]  cfg_payload;
    bit                    armed;
    logic [31:0]           latched_crc;
    logic [31:0]           crc_acc;
    logic [COUNT_BITS-1:0] bytes_seen;
    frame_result_t         awaited[$];
    int                    errors;
    int                    checked;
    int                    status_hits[8];

    function new();
      cfg_magic   = '0;
      cfg_version = '0;
      cfg_width   = '0;
      cfg_height  = '0;
      cfg_format  = '0;
      cfg_payload = '0;
      armed       = 1'b0;
      latched_crc = '0;
      crc_acc     = '0;
      bytes_seen  = '0;
      errors      = 0;
      checked     = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] data);
      logic [31:0] r;
      bit          fb;
      r = ~crc;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ data[i];
        r  = {1'b0, r[31:1]} ^ (fb ? IEEE_POLY : 32'd0);
      end
      return ~r;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_MAGIC:         cfg_magic   = value;
        REG_VERSION:       cfg_version = value[15:0];
        REG_PANEL_WIDTH:   cfg_width   = value[15:0];
        REG_PANEL_HEIGHT:  cfg_height  = value[15:0];
        REG_PIXEL_FORMAT:  cfg_format  = value[7:0];
        REG_PAYLOAD_BYTES: cfg_payload = value[PAYLOAD_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(item_t r);
      frame_result_t res;
      res.status = STATUS_INVALID;
      case (r.func)
        FUNC_HEADER: begin
          if (r.hdr_magic != cfg_magic) res.status = STATUS_INVALID;
          else if (r.hdr_version != cfg_version) res.status = STATUS_NOT_SUPPORTED;
          else if (r.hdr_width != cfg_width) res.status = STATUS_INVALID;
          else if (r.hdr_height != cfg_height) res.status = STATUS_INVALID;
          else if (r.hdr_format != cfg_format) res.status = STATUS_NOT_SUPPORTED;
          else if (r.hdr_payload_len != 32'(cfg_payload)) res.status = STATUS_INVALID;
          else res.status = STATUS_OK;
          armed = (res.status == STATUS_OK);
          if (armed) begin
            latched_crc = r.hdr_crc;
            crc_acc     = '0;
            bytes_seen  = '0;
          end
        end
        FUNC_BYTE: begin
          if (!armed) begin
            res.status = STATUS_INVALID;
          end else if (CNT_CMP_W'(bytes_seen) + 1 > CNT_CMP_W'(cfg_payload)) begin
            res.status = STATUS_TOO_BIG;
          end else begin
            crc_acc    = crc32_update(crc_acc, r.data_byte);
            bytes_seen = bytes_seen + 1'b1;
            res.status = STATUS_OK;
          end
        end
        FUNC_END: begin
          if (!armed || CNT_CMP_W'(bytes_seen) != CNT_CMP_W'(cfg_payload)) begin
            res.status = STATUS_INVALID;
          end else if (crc_acc != latched_crc) begin
            res.status = STATUS_BAD_CRC;
          end else begin
            res.status = STATUS_OK;
          end
        end
        default: res.status = STATUS_INVALID;
      endcase
      res.crc = crc_acc;
      awaited.push_back(res);
    endfunction

    function void check_result(logic [2:0] status, logic [31:0] crc);
      frame_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result without a request: status %0d, crc %08h", $time, status, crc);
        return;
      end
      want = awaited.pop_front();
      checked++;
      status_hits[want.status]++;
      if (status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
      end
      if (crc !== want.crc) begin
        errors++;
        $display("%0t: running CRC expected %08h, got %08h", $time, want.crc, crc);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_func;
  logic [31:0]           in_hdr_magic;
  logic [15:0]           in_hdr_version;
  logic [15:0]           in_hdr_width;
  logic [15:0]           in_hdr_height;
  logic [7:0]            in_hdr_format;
  logic [31:0]           in_hdr_payload_len;
  logic [31:0]           in_hdr_crc;
  logic [7:0]            in_data_byte;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [2:0]            out_status;
  logic [31:0]           out_running_crc;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  frame_status_board board = new();
  bit                idling = 1'b1;
  int                ready_hold = 0;
  int                cycle_count = 0;
  int                requests_sent = 0;
  int                settings_used = 0;

  frame_header_crc_checker_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_hdr_magic       (in_hdr_magic),
    .in_hdr_version     (in_hdr_version),
    .in_hdr_width       (in_hdr_width),
    .in_hdr_height      (in_hdr_height),
    .in_hdr_format      (in_hdr_format),
    .in_hdr_payload_len (in_hdr_payload_len),
    .in_hdr_crc         (in_hdr_crc),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_running_crc    (out_running_crc),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      ready_hold <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_status, out_running_crc);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic item_t noise_item(input logic [1:0] func);
    item_t r;
    r.func            = func;
    r.hdr_magic       = $urandom;
    r.hdr_version     = 16'($urandom);
    r.hdr_width       = 16'($urandom);
    r.hdr_height      = 16'($urandom);
    r.hdr_format      = 8'($urandom);
    r.hdr_payload_len = $urandom;
    r.hdr_crc         = $urandom;
    r.data_byte       = 8'($urandom);
    return r;
  endfunction

  function automatic item_t header_item(input logic [31:0] crc);
    item_t r;
    r                 = noise_item(FUNC_HEADER);
    r.hdr_magic       = board.cfg_magic;
    r.hdr_version     = board.cfg_version;
    r.hdr_width       = board.cfg_width;
    r.hdr_height      = board.cfg_height;
    r.hdr_format      = board.cfg_format;
    r.hdr_payload_len = 32'(board.cfg_payload);
    r.hdr_crc         = crc;
    return r;
  endfunction

  function automatic item_t byte_item(input logic [7:0] data);
    item_t r;
    r           = noise_item(FUNC_BYTE);
    r.data_byte = data;
    return r;
  endfunction

  function automatic item_t spoil_header(input item_t r, input reg_idx_t which);
    case (which)
      REG_MAGIC:         r.hdr_magic       ^= 32'd1 << $urandom_range(0, 31);
      REG_VERSION:       r.hdr_version     ^= 16'd1 << $urandom_range(0, 15);
      REG_PANEL_WIDTH:   r.hdr_width       ^= 16'd1 << $urandom_range(0, 15);
      REG_PANEL_HEIGHT:  r.hdr_height      ^= 16'd1 << $urandom_range(0, 15);
      REG_PIXEL_FORMAT:  r.hdr_format      ^= 8'd1 << $urandom_range(0, 7);
      REG_PAYLOAD_BYTES: r.hdr_payload_len ^= 32'd1 << $urandom_range(0, 31);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input item_t r);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_func            <= r.func;
    in_hdr_magic       <= r.hdr_magic;
    in_hdr_version     <= r.hdr_version;
    in_hdr_width       <= r.hdr_width;
    in_hdr_height      <= r.hdr_height;
    in_hdr_format      <= r.hdr_format;
    in_hdr_payload_len <= r.hdr_payload_len;
    in_hdr_crc         <= r.hdr_crc;
    in_data_byte       <= r.data_byte;
    do @(posedge clk); while (!in_ready);
    board.note_request(r);
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, value);
  endtask

  task automatic apply_setting(input logic [31:0] magic, input logic [15:0] version,
                               input logic [15:0] width, input logic [15:0] height,
                               input logic [7:0] format, input logic [PAYLOAD_W-1:0] length);
    wait_idle();
    write_reg(REG_MAGIC, magic);
    write_reg(REG_VERSION, 32'(version));
    write_reg(REG_PANEL_WIDTH, 32'(width));
    write_reg(REG_PANEL_HEIGHT, 32'(height));
    write_reg(REG_PIXEL_FORMAT, 32'(format));
    write_reg(REG_PAYLOAD_BYTES, 32'(length));
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  task automatic random_setting(input logic [PAYLOAD_W-1:0] length);
    apply_setting($urandom, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), length);
  endtask

  task automatic send_frame(input bit crc_ok, input body_shape_t shape);
    logic [7:0]  body [MAX_BODY+1];
    logic [31:0] crc;
    int          len;
    int          sent_len;
    crc = '0;
    if (board.cfg_payload <= MAX_BODY) len = int'(board.cfg_payload);
    else len = $urandom_range(0, MAX_BODY);
    for (int i = 0; i <= MAX_BODY; i++) body[i] = 8'($urandom);
    for (int i = 0; i < len; i++) crc = board.crc32_update(crc, body[i]);
    if (!crc_ok) crc ^= 32'd1 << $urandom_range(0, 31);
    case (shape)
      BODY_SHORT: sent_len = (len > 0) ? len - 1 : 0;
      BODY_LONG:  sent_len = len + 1;
      default:    sent_len = len;
    endcase
    send_request(header_item(crc));
    for (int i = 0; i < sent_len; i++) send_request(byte_item(body[i]));
    send_request(noise_item(FUNC_END));
  endtask

  task automatic random_traffic(input int count);
    int          stop_at;
    int          pick;
    int          roll;
    body_shape_t shape;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
        wait_idle();
      end else if (pick <= 26) begin
        roll  = $urandom_range(0, 9);
        shape = (roll < 7) ? BODY_EXACT : (roll < 9) ? BODY_SHORT : BODY_LONG;
        send_frame($urandom_range(0, 4) != 0, shape);
      end else if (pick <= 32) begin
        send_request(spoil_header(header_item($urandom),
                                  reg_idx_t'($urandom_range(REG_MAGIC, REG_PAYLOAD_BYTES))));
      end else if (pick <= 35) begin
        send_request(noise_item(2'($urandom)));
      end else if (pick <= 37) begin
        send_request(noise_item(FUNC_BYTE));
      end else begin
        send_request(noise_item(FUNC_END));
      end
    end
  endtask

  initial begin
    logic [7:0]  sample_body [4];
    logic [31:0] sample_crc;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_func            <= FUNC_HEADER;
    in_hdr_magic       <= '0;
    in_hdr_version     <= '0;
    in_hdr_width       <= '0;
    in_hdr_height      <= '0;
    in_hdr_format      <= '0;
    in_hdr_payload_len <= '0;
    in_hdr_crc         <= '0;
    in_data_byte       <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers are all zero, so an all-zero header with an empty payload passes.
    send_request(byte_item(8'h00));
    send_request(noise_item(FUNC_END));
    send_request(header_item(32'd0));
    send_request(byte_item(8'hFF));
    send_request(noise_item(FUNC_END));

    apply_setting('1, '1, '1, '1, '1, 24'd4);
    send_request(noise_item(FUNC_SPARE));
    send_request(noise_item(FUNC_END));
    for (int f = REG_MAGIC; f <= REG_PAYLOAD_BYTES; f++) begin
      send_request(spoil_header(header_item(32'd0), reg_idx_t'(f)));
    end
    send_request(byte_item(8'h5A));
    sample_body = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    sample_crc  = '0;
    foreach (sample_body[i]) sample_crc = board.crc32_update(sample_crc, sample_body[i]);
    send_request(header_item(sample_crc));
    send_request(byte_item(sample_body[0]));
    send_request(byte_item(sample_body[1]));
    send_request(noise_item(FUNC_END));
    send_request(byte_item(sample_body[2]));
    send_request(byte_item(sample_body[3]));
    send_request(byte_item(8'h33));
    send_request(noise_item(FUNC_END));
    send_request(header_item(~sample_crc));
    foreach (sample_body[i]) send_request(byte_item(sample_body[i]));
    send_request(noise_item(FUNC_END));

    random_setting(24'($urandom_range(1, 12)));
    random_traffic(200);
    apply_setting('0, '0, '0, '0, '0, '0);
    random_traffic(60);
    random_setting('1);
    random_traffic(20);
    random_setting(24'd16);
    random_traffic(75);
    idling = 1'b0;
    random_traffic(50);
    idling = 1'b1;
    random_traffic(25);
    idling = 1'b0;
    random_setting(24'($urandom_range(1, 8)));
    random_traffic(150);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests under %0d register settings; %0d results checked.",
             requests_sent, settings_used, board.checked);
    $display("Statuses: ok %0d, invalid %0d, not supported %0d, too big %0d, bad CRC %0d.",
             board.status_hits[STATUS_OK], board.status_hits[STATUS_INVALID],
             board.status_hits[STATUS_NOT_SUPPORTED], board.status_hits[STATUS_TOO_BIG],
             board.status_hits[STATUS_BAD_CRC]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
